@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled in reset.
`define TRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ hdl/tra_pkg.sv @@
// Types and constants for the task run-time accounting block.
package tra_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_OUT   = 8;
    localparam int REP_N     = (NUM_SLOTS < MAX_OUT) ? NUM_SLOTS : MAX_OUT;

    localparam logic [31:0] FULL_SCALE  = 32'd1000000;
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    // floor(t / 10000) = (t * RECIP) >> RECIP_SHIFT for t <= FULL_SCALE
    localparam logic [20:0] RECIP       = 21'd1717987;
    localparam int          RECIP_SHIFT = 34;
    localparam int          PROD_W      = 41;

    typedef enum logic [1:0] {
        REQ_IN     = 2'd0,
        REQ_OUT    = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_BAD    = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_DROP   = 2'd1,
        STS_REPORT = 2'd2,
        STS_RSVD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SUM,
        S_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] task_key;
        logic [15:0] timer_now;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot_index;
        logic        slot_used;
        logic [31:0] slot_key;
        logic [6:0]  usage_percent;
        logic        last_result;
    } t_res;

endpackage

@@ hdl/task_runtime_accounting.sv @@
// Task run-time accounting table: slot search, run-time update and usage report.
//
// Command channel: drive i_req and raise i_start; the beat is taken at a rising
// edge with i_start high and o_busy low. Results leave on o_res, each valid for
// exactly one cycle while o_strobe is high; the receiver cannot stall them.
// Switch-in / switch-out: one sequencer scans the slots one per cycle through a
// single key comparator in S_SCAN, then S_APPLY updates the slot. o_busy is
// high from acceptance through S_APPLY, and the result strobes the cycle after.
// A dropped beat (key zero or unknown request) gives its result the next cycle
// and does not raise o_busy.
// Report: S_SUM adds the run totals of used slots through one adder, then for
// each slot S_LOAD reads the total, multiplies it by a reciprocal and clears
// the slot's total and stamp, and S_EMIT emits; up to 8 results come out.
// Synchronous reset empties all slots and clears totals and stamps.
`include "assert_macros.svh"

module task_runtime_accounting (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tra_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_strobe,
    output tra_pkg::t_res  o_res
);
    import tra_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    t_req                r_req, n_req;
    logic                r_hit, n_hit;
    logic [SLOT_W-1:0]   r_hit_idx, n_hit_idx;
    logic                r_free, n_free;
    logic [SLOT_W-1:0]   r_free_idx, n_free_idx;
    logic [31:0]         r_sum, n_sum;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_sat, n_sat;
    logic                r_used, n_used;
    logic [31:0]         r_rkey, n_rkey;
    logic                r_strobe, n_strobe;
    t_res                r_res, n_res;

    logic [31:0]         r_keys   [NUM_SLOTS];
    logic [15:0]         r_stamps [NUM_SLOTS];
    logic [31:0]         r_totals [NUM_SLOTS];
    logic [31:0]         n_keys   [NUM_SLOTS];
    logic [15:0]         n_stamps [NUM_SLOTS];
    logic [31:0]         n_totals [NUM_SLOTS];

    logic [SLOT_W-1:0]   slot;
    logic [31:0]         key_rd;
    logic [31:0]         tot_rd;
    logic [15:0]         stamp_src;
    logic [31:0]         total_src;
    logic [15:0]         delta;
    logic [6:0]          pct;

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_req      = r_req;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_sum      = r_sum;
        n_prod     = r_prod;
        n_sat      = r_sat;
        n_used     = r_used;
        n_rkey     = r_rkey;
        n_strobe   = 1'b0;
        n_res      = r_res;
        n_keys     = r_keys;
        n_stamps   = r_stamps;
        n_totals   = r_totals;

        key_rd    = r_keys[r_idx];
        tot_rd    = r_totals[r_idx];
        slot      = r_hit ? r_hit_idx : r_free_idx;
        stamp_src = r_hit ? r_stamps[slot] : 16'd0;
        total_src = r_hit ? r_totals[slot] : 32'd0;
        delta     = r_req.timer_now - stamp_src;
        pct       = (!r_used || r_sum == 32'd0) ? 7'd0
                  : r_sat ? PCT_MAX : 7'(r_prod >> RECIP_SHIFT);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_idx = '0;
                    if (i_req.req_type == REQ_REPORT) begin
                        n_sum   = 32'd0;
                        n_state = S_SUM;
                    end else if (i_req.req_type == REQ_BAD || i_req.task_key == 32'd0) begin
                        n_strobe = 1'b1;
                        n_res    = '{status: STS_DROP, slot_index: 3'd0, slot_used: 1'b0,
                                     slot_key: 32'd0, usage_percent: 7'd0, last_result: 1'b1};
                    end else begin
                        n_hit   = 1'b0;
                        n_free  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!r_hit && key_rd == r_req.task_key) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!r_free && key_rd == 32'd0) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_APPLY;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_APPLY: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_hit || r_free) begin
                    n_keys[slot] = r_req.task_key;
                    if (r_req.req_type == REQ_IN) begin
                        n_stamps[slot] = r_req.timer_now;
                        n_totals[slot] = total_src;
                    end else begin
                        n_stamps[slot] = stamp_src;
                        n_totals[slot] = total_src + 32'(delta);
                    end
                    n_res = '{status: STS_OK, slot_index: 3'(slot), slot_used: 1'b1,
                              slot_key: r_req.task_key, usage_percent: 7'd0,
                              last_result: 1'b1};
                end else begin
                    n_res = '{status: STS_DROP, slot_index: 3'd0, slot_used: 1'b0,
                              slot_key: 32'd0, usage_percent: 7'd0, last_result: 1'b1};
                end
            end
            S_SUM: begin
                if (key_rd != 32'd0) begin
                    n_sum = r_sum + tot_rd;
                end
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LOAD: begin
                n_prod          = PROD_W'(tot_rd[19:0] * RECIP);
                n_sat           = (tot_rd > FULL_SCALE);
                n_used          = (key_rd != 32'd0);
                n_rkey          = key_rd;
                n_totals[r_idx] = 32'd0;
                n_stamps[r_idx] = 16'd0;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (32'(r_idx) < REP_N) begin
                    n_strobe = 1'b1;
                    n_res    = '{status: STS_REPORT, slot_index: 3'(r_idx), slot_used: r_used,
                                 slot_key: r_rkey, usage_percent: pct,
                                 last_result: (32'(r_idx) == REP_N - 1)};
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_keys[i]   <= 32'd0;
                r_stamps[i] <= 16'd0;
                r_totals[i] <= 32'd0;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
            r_hit    <= n_hit;
            r_free   <= n_free;
            r_keys   <= n_keys;
            r_stamps <= n_stamps;
            r_totals <= n_totals;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_sum      <= n_sum;
        r_prod     <= n_prod;
        r_sat      <= n_sat;
        r_used     <= n_used;
        r_rkey     <= n_rkey;
        r_res      <= n_res;
    end

    `TRA_ASSERT_NXT(a_accept_acts, i_clk, i_rst_n,
        i_start && !o_busy, o_busy || o_strobe)
    `TRA_ASSERT_IMP(a_report_last_idx, i_clk, i_rst_n,
        o_strobe && o_res.status == STS_REPORT && o_res.last_result,
        o_res.slot_index == 3'(REP_N - 1))
    `TRA_ASSERT_IMP(a_apply_strobes, i_clk, i_rst_n,
        r_state == S_APPLY, n_strobe && n_state == S_IDLE)

endmodule
